/* design/rgb_to_hsl_converter_defines.svh */
// Assertion macros for the RGB to HSL converter checker.
// Each macro expects signals named clock and reset in the calling scope.
`ifndef RGB_TO_HSL_CONVERTER_DEFINES_SVH
`define RGB_TO_HSL_CONVERTER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RHC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define RHC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/rhc_pkg.sv */
// Shared types, constants and the divider step for the RGB to HSL converter.
// No dependencies.
`timescale 1ns / 1ps

package rhc_pkg;

   localparam int CHAN_W   = 8;
   localparam int LSUM_W   = 9;
   localparam int FRAC_W   = 16;
   localparam int QUO_W    = FRAC_W + 1;      // quotient reaches exactly one
   localparam int HUE_W    = 19;
   localparam int SAT_W    = 16;
   localparam int DEN_W    = 9;
   localparam int PR_W     = DEN_W + 1;
   localparam int DIV_STEPS = QUO_W;

   localparam logic [LSUM_W-1:0] HALF_SUM = 9'd255;
   localparam logic [LSUM_W-1:0] FULL_SUM = 9'd510;

   // Sextant offset of the channel holding the maximum.
   typedef enum logic [2:0] {
      HUE_BASE_RED   = 3'd1,
      HUE_BASE_GREEN = 3'd3,
      HUE_BASE_BLUE  = 3'd5
   } hue_base_type;

   // One restoring-division lane: shifted partial remainder, divisor, quotient.
   typedef struct packed {
      logic [PR_W-1:0]  pr;
      logic [DEN_W-1:0] den;
      logic [QUO_W-1:0] quo;
   } lane_type;

   // Per-item data that rides along the divider.
   typedef struct packed {
      logic              grey;
      logic              neg;
      hue_base_type      base;
      logic [LSUM_W-1:0] lsum;
   } side_type;

   function automatic lane_type div_step(input lane_type l);
      lane_type        res;
      logic            ge;
      logic [PR_W-1:0] r;
      ge      = (l.pr >= {1'b0, l.den});
      r       = ge ? (l.pr - {1'b0, l.den}) : l.pr;
      res.pr  = {r[PR_W-2:0], 1'b0};
      res.den = l.den;
      res.quo = {l.quo[QUO_W-2:0], ge};
      return res;
   endfunction

endpackage

/* design/rhc_if.sv */
// Valid/ready channel interfaces for the pixel input and the HSL result.
// Depends on rhc_pkg for field widths.
`timescale 1ns / 1ps

interface rhc_req_if;
   logic                         valid;
   logic                         ready;
   logic [rhc_pkg::CHAN_W-1:0]   red;
   logic [rhc_pkg::CHAN_W-1:0]   green;
   logic [rhc_pkg::CHAN_W-1:0]   blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink   (input valid, red, green, blue, output ready);
endinterface

interface rhc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [rhc_pkg::HUE_W-1:0]    hue;
   logic [rhc_pkg::SAT_W-1:0]    saturation;
   logic [rhc_pkg::LSUM_W-1:0]   lightness_sum;

   modport source (output valid, hue, saturation, lightness_sum, input ready);
   modport sink   (input valid, hue, saturation, lightness_sum, output ready);
endinterface

/* design/rhc_front.sv */
// Front end: channel max/min and hue sector, then sums, divisors and
// the hue difference magnitude. Two register stages. Uses rhc_pkg.
`timescale 1ns / 1ps

module rhc_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [rhc_pkg::CHAN_W-1:0]   red,
   input  logic [rhc_pkg::CHAN_W-1:0]   green,
   input  logic [rhc_pkg::CHAN_W-1:0]   blue,
   output logic                         out_valid,
   output rhc_pkg::side_type            out_side,
   output rhc_pkg::lane_type            out_sat_lane,
   output rhc_pkg::lane_type            out_hue_lane
);

   // stage 1
   logic                       s1_valid_ff;
   logic [rhc_pkg::CHAN_W-1:0] s1_hi_ff, s1_lo_ff, s1_p_ff, s1_m_ff;
   rhc_pkg::hue_base_type      s1_base_ff;
   logic [rhc_pkg::CHAN_W-1:0] s1_hi_in, s1_lo_in, s1_p_in, s1_m_in;
   rhc_pkg::hue_base_type      s1_base_in;

   // stage 2
   logic                       s2_valid_ff;
   rhc_pkg::side_type          s2_side_ff, s2_side_in;
   rhc_pkg::lane_type          s2_sat_ff, s2_sat_in, s2_hue_ff, s2_hue_in;

   logic [rhc_pkg::CHAN_W-1:0] rg_max, rg_min, d;
   logic [rhc_pkg::LSUM_W-1:0] lsum;
   logic                       neg;
   logic [rhc_pkg::CHAN_W-1:0] absdiff;

   always_comb begin
      rg_max   = (red >= green) ? red : green;
      rg_min   = (red <= green) ? red : green;
      s1_hi_in = (rg_max >= blue) ? rg_max : blue;
      s1_lo_in = (rg_min <= blue) ? rg_min : blue;
      // red wins ties over green, green over blue
      if (red >= green && red >= blue) begin
         s1_base_in = rhc_pkg::HUE_BASE_RED;
         s1_p_in    = green;
         s1_m_in    = blue;
      end else if (green >= blue) begin
         s1_base_in = rhc_pkg::HUE_BASE_GREEN;
         s1_p_in    = blue;
         s1_m_in    = red;
      end else begin
         s1_base_in = rhc_pkg::HUE_BASE_BLUE;
         s1_p_in    = red;
         s1_m_in    = green;
      end
   end

   always_comb begin
      lsum    = {1'b0, s1_hi_ff} + {1'b0, s1_lo_ff};
      d       = s1_hi_ff - s1_lo_ff;
      neg     = (s1_p_ff < s1_m_ff);
      absdiff = neg ? (s1_m_ff - s1_p_ff) : (s1_p_ff - s1_m_ff);

      s2_side_in.grey = (s1_hi_ff == s1_lo_ff);
      s2_side_in.neg  = neg;
      s2_side_in.base = s1_base_ff;
      s2_side_in.lsum = lsum;

      s2_sat_in.pr  = {2'b00, d};
      s2_sat_in.den = (lsum < rhc_pkg::HALF_SUM) ? lsum : (rhc_pkg::FULL_SUM - lsum);
      s2_sat_in.quo = '0;

      s2_hue_in.pr  = {2'b00, absdiff};
      s2_hue_in.den = {1'b0, d};
      s2_hue_in.quo = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_hi_ff   <= s1_hi_in;
         s1_lo_ff   <= s1_lo_in;
         s1_p_ff    <= s1_p_in;
         s1_m_ff    <= s1_m_in;
         s1_base_ff <= s1_base_in;
         s2_side_ff <= s2_side_in;
         s2_sat_ff  <= s2_sat_in;
         s2_hue_ff  <= s2_hue_in;
      end
   end

   assign out_valid    = s2_valid_ff;
   assign out_side     = s2_side_ff;
   assign out_sat_lane = s2_sat_ff;
   assign out_hue_lane = s2_hue_ff;

endmodule

/* design/rhc_div_pipe.sv */
// Pipelined restoring divider: one quotient bit per stage for the
// saturation and hue lanes side by side. Uses rhc_pkg.
`timescale 1ns / 1ps

module rhc_div_pipe (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  rhc_pkg::side_type  in_side,
   input  rhc_pkg::lane_type  in_sat_lane,
   input  rhc_pkg::lane_type  in_hue_lane,
   output logic               out_valid,
   output rhc_pkg::side_type  out_side,
   output rhc_pkg::lane_type  out_sat_lane,
   output rhc_pkg::lane_type  out_hue_lane
);

   localparam int N = rhc_pkg::DIV_STEPS;

   logic              valid_ff [N];
   rhc_pkg::side_type side_ff  [N];
   rhc_pkg::lane_type sat_ff   [N];
   rhc_pkg::lane_type hue_ff   [N];
   logic              valid_in [N];
   rhc_pkg::side_type side_in  [N];
   rhc_pkg::lane_type sat_in   [N];
   rhc_pkg::lane_type hue_in   [N];

   always_comb begin
      valid_in[0] = in_valid;
      side_in[0]  = in_side;
      sat_in[0]   = rhc_pkg::div_step(in_sat_lane);
      hue_in[0]   = rhc_pkg::div_step(in_hue_lane);
      for (int i = 1; i < N; i++) begin
         valid_in[i] = valid_ff[i-1];
         side_in[i]  = side_ff[i-1];
         sat_in[i]   = rhc_pkg::div_step(sat_ff[i-1]);
         hue_in[i]   = rhc_pkg::div_step(hue_ff[i-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N; i++) valid_ff[i] <= 1'b0;
      end else if (en) begin
         for (int i = 0; i < N; i++) valid_ff[i] <= valid_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < N; i++) begin
            side_ff[i] <= side_in[i];
            sat_ff[i]  <= sat_in[i];
            hue_ff[i]  <= hue_in[i];
         end
      end
   end

   assign out_valid    = valid_ff[N-1];
   assign out_side     = side_ff[N-1];
   assign out_sat_lane = sat_ff[N-1];
   assign out_hue_lane = hue_ff[N-1];

endmodule

/* design/rgb_to_hsl_converter.sv */
// RGB to HSL converter top level: input skid slot, front end, divider
// pipeline and output register. Uses rhc_pkg, rhc_if, rhc_front, rhc_div_pipe.
//
// Usage:
//   req_chan carries one pixel (red, green, blue, 8 bits each) per item.
//   rsp_chan returns hue (Q3.16 sextants), saturation (Q0.16, 65535 for one)
//   and lightness_sum (max + min, lightness = lightness_sum / 510).
//   Both channels move an item at a clock edge where valid and ready are high.
// Path: a result shows on rsp_chan after its pixel has passed through the
//   two front-end stages, 17 divider stages (one quotient bit each) and the
//   output register.
// Throughput: one pixel per cycle sustained while rsp_chan.ready stays high;
//   the 17-stage divider pipeline holds up to 17 items in flight.
// Stall: when the receiver holds rsp_chan.ready low with a result waiting,
//   the whole pipeline freezes; one more pixel is still taken into a skid
//   slot, after which req_chan.ready drops until the output moves again.
//   Nothing is dropped or repeated.
// Reset: synchronous; clears all valid bits, so the pipeline comes up empty
//   and ready.
`timescale 1ns / 1ps

module rgb_to_hsl_converter (
   input  logic          clock,
   input  logic          reset,
   rhc_req_if.sink       req_chan,
   rhc_rsp_if.source     rsp_chan
);

   logic                        skid_valid_ff, skid_valid_in;
   logic [rhc_pkg::CHAN_W-1:0]  skid_red_ff, skid_green_ff, skid_blue_ff;
   logic                        en;
   logic                        src_valid;
   logic [rhc_pkg::CHAN_W-1:0]  src_red, src_green, src_blue;

   logic                        fe_valid;
   rhc_pkg::side_type           fe_side;
   rhc_pkg::lane_type           fe_sat, fe_hue;
   logic                        dv_valid;
   rhc_pkg::side_type           dv_side;
   rhc_pkg::lane_type           dv_sat, dv_hue;

   logic                        rsp_valid_ff;
   logic [rhc_pkg::HUE_W-1:0]   hue_ff, hue_in;
   logic [rhc_pkg::SAT_W-1:0]   sat_ff, sat_in;
   logic [rhc_pkg::LSUM_W-1:0]  lsum_ff;
   logic [rhc_pkg::HUE_W-1:0]   hue_base, hue_quo;

   // advance whenever the output slot is free or being emptied
   assign en             = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !skid_valid_ff;

   assign src_valid = skid_valid_ff || req_chan.valid;
   assign src_red   = skid_valid_ff ? skid_red_ff   : req_chan.red;
   assign src_green = skid_valid_ff ? skid_green_ff : req_chan.green;
   assign src_blue  = skid_valid_ff ? skid_blue_ff  : req_chan.blue;

   always_comb begin
      skid_valid_in = skid_valid_ff;
      if (en) begin
         skid_valid_in = 1'b0;
      end else if (req_chan.valid && !skid_valid_ff) begin
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else begin
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_valid_ff) begin
         skid_red_ff   <= req_chan.red;
         skid_green_ff <= req_chan.green;
         skid_blue_ff  <= req_chan.blue;
      end
   end

   rhc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (src_valid),
      .red          (src_red),
      .green        (src_green),
      .blue         (src_blue),
      .out_valid    (fe_valid),
      .out_side     (fe_side),
      .out_sat_lane (fe_sat),
      .out_hue_lane (fe_hue)
   );

   rhc_div_pipe u_div (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (fe_valid),
      .in_side      (fe_side),
      .in_sat_lane  (fe_sat),
      .in_hue_lane  (fe_hue),
      .out_valid    (dv_valid),
      .out_side     (dv_side),
      .out_sat_lane (dv_sat),
      .out_hue_lane (dv_hue)
   );

   always_comb begin
      hue_base = {dv_side.base, {rhc_pkg::FRAC_W{1'b0}}};
      hue_quo  = {{(rhc_pkg::HUE_W - rhc_pkg::QUO_W){1'b0}}, dv_hue.quo};
      if (dv_side.grey) begin
         hue_in = '0;
         sat_in = '0;
      end else begin
         hue_in = dv_side.neg ? (hue_base - hue_quo) : (hue_base + hue_quo);
         // clamp a quotient of exactly one
         sat_in = dv_sat.quo[rhc_pkg::QUO_W-1] ? {rhc_pkg::SAT_W{1'b1}}
                                               : dv_sat.quo[rhc_pkg::SAT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hue_ff  <= hue_in;
         sat_ff  <= sat_in;
         lsum_ff <= dv_side.lsum;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.hue           = hue_ff;
   assign rsp_chan.saturation    = sat_ff;
   assign rsp_chan.lightness_sum = lsum_ff;

endmodule

/* design/rhc_checker.sv */
// Port-level checker for the RGB to HSL converter, bound to the top level.
// Uses rgb_to_hsl_converter_defines.svh and rhc_pkg.
`timescale 1ns / 1ps
`include "rgb_to_hsl_converter_defines.svh"

module rhc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [rhc_pkg::HUE_W-1:0]   hue,
   input logic [rhc_pkg::SAT_W-1:0]   saturation,
   input logic [rhc_pkg::LSUM_W-1:0]  lightness_sum
);

   `RHC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(hue) && $stable(saturation) && $stable(lightness_sum), "stalled item changed")
   `RHC_ASSERT_NOW(a_empty_after_reset, $past(reset), !rsp_valid, "item out right after reset")
   `RHC_ASSERT_NOW(a_grey_hue, rsp_valid && saturation == '0, hue == '0, "zero saturation with nonzero hue")
   `RHC_ASSERT_NOW(a_black_grey, rsp_valid && lightness_sum == '0, saturation == '0, "black pixel with saturation")
   `RHC_ASSERT_NOW(a_hue_range, rsp_valid, hue < 19'd393216 && lightness_sum <= 9'd510, "hue or lightness out of range")

endmodule

bind rgb_to_hsl_converter rhc_checker u_rhc_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .hue           (rsp_chan.hue),
   .saturation    (rsp_chan.saturation),
   .lightness_sum (rsp_chan.lightness_sum)
);
